FILE: hw/rtl/mbc3_bank_controller_rtc_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MBC3_BANK_CONTROLLER_RTC_CORE_ASSERT_SVH
`define MBC3_BANK_CONTROLLER_RTC_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBC3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mbc3_pkg.sv
`timescale 1ns / 1ps
package mbc3_pkg;

    localparam int RAM_BYTES_DEF     = 32768;
    localparam int ROM_ADDR_BITS_DEF = 21;

    // Item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result targets
    localparam logic [1:0] TGT_DATA = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_NONE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROM_BYTES  = 2'd0;
    localparam logic [1:0] CFG_RAM_TOTAL  = 2'd1;
    localparam logic [1:0] CFG_RAM_STRIDE = 2'd2;

    // Clock register selects
    localparam logic [7:0] RTC_SEC  = 8'h08;
    localparam logic [7:0] RTC_MIN  = 8'h09;
    localparam logic [7:0] RTC_HR   = 8'h0A;
    localparam logic [7:0] RTC_DAYL = 8'h0B;
    localparam logic [7:0] RTC_CTRL = 8'h0C;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] rom_address;
        logic [7:0]  read_data;
        logic        out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [8:0] days;
        logic       halt;
        logic       day_ovf;
    } rtc_t;

endpackage

FILE: hw/rtl/mbc3_rtc_tick.sv
`timescale 1ns / 1ps
module mbc3_rtc_tick
    import mbc3_pkg::*;
(
    input  rtc_t cur,
    output rtc_t nxt
);

    localparam int SEC_PER_MIN = 60;
    localparam int HR_PER_DAY  = 24;
    localparam int MAX_Q60     = 255 / SEC_PER_MIN;
    localparam int MAX_Q24     = 255 / HR_PER_DAY;

    typedef struct packed {
        logic [3:0] q;
        logic [7:0] r;
    } divmod_t;

    // Quotient and remainder by independent threshold compares.
    function automatic divmod_t div60(input logic [7:0] v);
        divmod_t res;
        res.q = '0;
        res.r = v;
        for (int k = 1; k <= MAX_Q60; k++)
        begin
            if (v >= 8'(k * SEC_PER_MIN))
            begin
                res.q = 4'(k);
                res.r = v - 8'(k * SEC_PER_MIN);
            end
        end
        return res;
    endfunction

    function automatic divmod_t div24(input logic [7:0] v);
        divmod_t res;
        res.q = '0;
        res.r = v;
        for (int k = 1; k <= MAX_Q24; k++)
        begin
            if (v >= 8'(k * HR_PER_DAY))
            begin
                res.q = 4'(k);
                res.r = v - 8'(k * HR_PER_DAY);
            end
        end
        return res;
    endfunction

    always_comb
    begin
        logic [7:0] s;
        logic [7:0] m;
        logic [7:0] h;
        logic [9:0] dsum;
        divmod_t    dm;
        nxt  = cur;
        s    = cur.seconds + 8'd1;
        m    = cur.minutes;
        h    = cur.hours;
        dsum = '0;
        dm   = '0;
        if (!cur.halt)
        begin
            if (s >= 8'(SEC_PER_MIN))
            begin
                dm = div60(s);
                m  = m + {4'd0, dm.q};
                s  = dm.r;
            end
            if (m >= 8'(SEC_PER_MIN))
            begin
                dm = div60(m);
                h  = h + {4'd0, dm.q};
                m  = dm.r;
            end
            nxt.seconds = s;
            nxt.minutes = m;
            nxt.hours   = h;
            if (h >= 8'(HR_PER_DAY))
            begin
                dm          = div24(h);
                dsum        = {1'b0, cur.days} + {6'd0, dm.q};
                nxt.hours   = dm.r;
                nxt.days    = dsum[8:0];
                // day counter overflow sets the sticky carry
                if (dsum[9])
                begin
                    nxt.day_ovf = 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/mbc3_bank_controller_rtc_core.sv
`timescale 1ns / 1ps
// Output: a result is offered in the cycle after its input transfer.
// Throughput: one item per cycle while results are not stalled; the single-port cart RAM
// takes one read or write a cycle. Reset: control registers return to defaults, then a
// clearing pass zeroes all RAM_BYTES bytes of the cart RAM (32768 by default), one byte
// a cycle, with in_ready low. Configuration writes are taken during the clearing pass.
module mbc3_bank_controller_rtc_core
    import mbc3_pkg::*;
#(
    parameter int RAM_BYTES     = RAM_BYTES_DEF,
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    localparam int          RAM_AW    = $clog2(RAM_BYTES);
    localparam logic [16:0] RAM_LIMIT = 17'(RAM_BYTES);
    localparam logic [21:0] ROM_LIMIT = 22'(1) << ROM_ADDR_BITS;
    localparam logic [RAM_AW-1:0] CLEAR_LAST = RAM_AW'(RAM_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [RAM_AW-1:0] clear_addr_reg;

    logic [21:0] rom_bytes_reg;
    logic [15:0] ram_total_reg;
    logic [13:0] ram_stride_reg;

    logic [6:0] rom_sel_reg, rom_sel_next;
    logic [1:0] ram_page_reg, ram_page_next;
    logic [7:0] enable_reg, enable_next;
    logic [7:0] clock_select_reg, clock_select_next;
    logic [7:0] latch_reg, latch_next;
    rtc_t       live_reg, live_next;
    rtc_t       latched_reg, latched_next;
    rtc_t       live_ticked;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_res_reg, out_res;
    logic      out_from_ram_reg, out_from_ram;

    logic [7:0] ram_mem [RAM_BYTES];
    logic [7:0] ram_q_reg;
    logic [RAM_AW-1:0] mem_addr;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic       ram_re;
    logic       ram_we_item;

    logic        accept;
    logic [20:0] rom_a;
    logic        rom_oor;
    logic        ram_region;
    logic        ram_enabled;
    logic        clk_hit;
    logic        use_latched;
    rtc_t        sel_rtc;
    logic [7:0]  clock_rd;
    logic [15:0] ram_pos;
    logic        ram_ok;

    mbc3_rtc_tick u_tick (
        .cur (live_reg),
        .nxt (live_ticked)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_item = out_res_reg;
        if (out_from_ram_reg)
        begin
            out_item.read_data = ram_q_reg;
        end
    end

    // Address decode
    assign rom_a = in_item.address[14] ? {rom_sel_reg, in_item.address[13:0]}
                                       : {7'd0, in_item.address[13:0]};
    assign rom_oor = ({1'b0, rom_a} >= rom_bytes_reg) || ({1'b0, rom_a} >= ROM_LIMIT);
    assign ram_region  = (in_item.address[15:13] == 3'b101);
    assign ram_enabled = ((enable_reg & 8'h0A) == 8'h0A);
    assign clk_hit     = clock_select_reg inside {[RTC_SEC:RTC_CTRL]};
    assign use_latched = (latch_reg == 8'd1);
    assign sel_rtc     = use_latched ? latched_reg : live_reg;
    assign ram_pos     = 16'(ram_page_reg) * 16'(ram_stride_reg)
                       + {3'd0, in_item.address[12:0]};
    assign ram_ok      = (ram_pos < ram_total_reg) && ({1'b0, ram_pos} < RAM_LIMIT);

    always_comb
    begin
        case (clock_select_reg)
            RTC_SEC:  clock_rd = sel_rtc.seconds;
            RTC_MIN:  clock_rd = sel_rtc.minutes;
            RTC_HR:   clock_rd = sel_rtc.hours;
            RTC_DAYL: clock_rd = sel_rtc.days[7:0];
            RTC_CTRL: clock_rd = {sel_rtc.day_ovf, sel_rtc.halt, 5'd0, sel_rtc.days[8]};
            default:  clock_rd = 8'h00;
        endcase
    end

    always_comb
    begin
        rtc_t mod;
        rom_sel_next      = rom_sel_reg;
        ram_page_next     = ram_page_reg;
        enable_next       = enable_reg;
        clock_select_next = clock_select_reg;
        latch_next        = latch_reg;
        live_next         = live_reg;
        latched_next      = latched_reg;
        out_res.target       = TGT_NONE;
        out_res.rom_address  = '0;
        out_res.read_data    = '0;
        out_res.out_of_range = 1'b0;
        out_from_ram = 1'b0;
        ram_re       = 1'b0;
        ram_we_item  = 1'b0;
        mod          = sel_rtc;
        if (accept)
        begin
            case (in_item.kind)
                KIND_READ:
                begin
                    out_res.target    = TGT_DATA;
                    out_res.read_data = 8'hFF;
                    if (!in_item.address[15])
                    begin
                        if (rom_oor)
                        begin
                            out_res.out_of_range = 1'b1;
                        end
                        else
                        begin
                            out_res.target      = TGT_ROM;
                            out_res.rom_address = rom_a;
                            out_res.read_data   = 8'h00;
                        end
                    end
                    else if (ram_region && ram_enabled)
                    begin
                        if (clk_hit)
                        begin
                            out_res.read_data = clock_rd;
                        end
                        else if (ram_ok)
                        begin
                            ram_re       = 1'b1;
                            out_from_ram = 1'b1;
                        end
                        else
                        begin
                            out_res.out_of_range = 1'b1;
                        end
                    end
                end
                KIND_WRITE:
                begin
                    case (in_item.address[15:13])
                        3'b000:
                        begin
                            enable_next = in_item.write_data;
                        end
                        3'b001:
                        begin
                            rom_sel_next = (in_item.write_data[6:0] == 7'd0)
                                         ? 7'd1 : in_item.write_data[6:0];
                        end
                        3'b010:
                        begin
                            clock_select_next = in_item.write_data;
                            if (in_item.write_data < 8'h04)
                            begin
                                ram_page_next = in_item.write_data[1:0];
                            end
                        end
                        3'b011:
                        begin
                            // latch on the zero-to-one write sequence
                            if (in_item.write_data == 8'd1 && latch_reg == 8'd0)
                            begin
                                latched_next = live_reg;
                            end
                            latch_next = in_item.write_data;
                        end
                        3'b101:
                        begin
                            if (ram_enabled)
                            begin
                                if (clk_hit)
                                begin
                                    case (clock_select_reg)
                                        RTC_SEC:  mod.seconds = in_item.write_data;
                                        RTC_MIN:  mod.minutes = in_item.write_data;
                                        RTC_HR:   mod.hours   = in_item.write_data;
                                        RTC_DAYL: mod.days[7:0] = in_item.write_data;
                                        RTC_CTRL:
                                        begin
                                            mod.days[8] = in_item.write_data[0];
                                            mod.halt    = in_item.write_data[6];
                                            mod.day_ovf = in_item.write_data[7];
                                        end
                                        default: ;
                                    endcase
                                    if (use_latched)
                                    begin
                                        latched_next = mod;
                                    end
                                    else
                                    begin
                                        live_next = mod;
                                    end
                                end
                                else if (ram_ok)
                                begin
                                    ram_we_item = 1'b1;
                                end
                                else
                                begin
                                    out_res.out_of_range = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                KIND_TICK:
                begin
                    live_next = live_ticked;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == CLEAR_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: state_next = ST_RUN;
            default: state_next = ST_CLEAR;
        endcase
    end

    assign out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign mem_we    = (state_reg == ST_CLEAR) || ram_we_item;
    assign mem_addr  = (state_reg == ST_CLEAR) ? clear_addr_reg : ram_pos[RAM_AW-1:0];
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'h00 : in_item.write_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ram_mem[mem_addr] <= mem_wdata;
        end
        if (ram_re)
        begin
            ram_q_reg <= ram_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_addr_reg   <= '0;
            rom_sel_reg      <= 7'd1;
            ram_page_reg     <= 2'd0;
            enable_reg       <= 8'd0;
            clock_select_reg <= 8'd0;
            latch_reg        <= 8'd0;
            live_reg         <= '0;
            latched_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_addr_reg <= clear_addr_reg + RAM_AW'(1);
            end
            rom_sel_reg      <= rom_sel_next;
            ram_page_reg     <= ram_page_next;
            enable_reg       <= enable_next;
            clock_select_reg <= clock_select_next;
            latch_reg        <= latch_next;
            live_reg         <= live_next;
            latched_reg      <= latched_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bytes_reg  <= 22'd2097152;
            ram_total_reg  <= 16'd32768;
            ram_stride_reg <= 14'd8192;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROM_BYTES:  rom_bytes_reg  <= cfg_data;
                CFG_RAM_TOTAL:  ram_total_reg  <= cfg_data[15:0];
                CFG_RAM_STRIDE: ram_stride_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Hold the result until its transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg      <= out_res;
            out_from_ram_reg <= out_from_ram;
        end
    end

endmodule

FILE: hw/rtl/mbc3_bank_controller_rtc_core_checker.sv
`timescale 1ns / 1ps
`include "mbc3_bank_controller_rtc_core_assert.svh"
module mbc3_bank_controller_rtc_core_checker
    import mbc3_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `MBC3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")
    `MBC3_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "no result after input transfer")
    `MBC3_ASSERT_IMP(a_rom_clean, clk, rst_n, out_valid && out_item.target == TGT_ROM, out_item.read_data == 8'h00 && !out_item.out_of_range, "ROM fetch carries data or range flag")
    `MBC3_ASSERT_IMP(a_none_clean, clk, rst_n, out_valid && out_item.target == TGT_NONE, out_item.read_data == 8'h00 && out_item.rom_address == 21'd0, "empty result carries payload")
    `MBC3_ASSERT_IMP(a_data_addr, clk, rst_n, out_valid && out_item.target == TGT_DATA, out_item.rom_address == 21'd0, "data result carries ROM address")

endmodule

bind mbc3_bank_controller_rtc_core mbc3_bank_controller_rtc_core_checker u_checker (.*);
